// ----- hw/rtl/edrt_pkg.sv -----
// Shared types, codes and constants of the emulated disk request translator.
`default_nettype none

package edrt_pkg;

  // Geometry of the image: 512-byte sectors packed four to a 2048-byte CD block.
  // Both must stay powers of two.
  localparam int unsigned SECTOR_BYTES      = 512;
  localparam int unsigned SECTORS_PER_BLOCK = 4;
  localparam int unsigned SECTOR_SHIFT      = $clog2(SECTOR_BYTES);
  localparam int unsigned SPB_SHIFT         = $clog2(SECTORS_PER_BLOCK);
  localparam int unsigned SKIP_MAX          = (SECTORS_PER_BLOCK - 1) * SECTOR_BYTES;

  // Linear sector index width: (cyl * heads + head) * spt + sector - 1 < 2^27
  localparam int unsigned VLBA_W = 27;
  localparam int unsigned MUL_A_W = 20;
  localparam int unsigned MUL_B_W = 9;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Service function codes (AH)
  localparam logic [7:0] FN_RESET       = 8'h00;
  localparam logic [7:0] FN_STATUS      = 8'h01;
  localparam logic [7:0] FN_READ        = 8'h02;
  localparam logic [7:0] FN_WRITE       = 8'h03;
  localparam logic [7:0] FN_VERIFY      = 8'h04;
  localparam logic [7:0] FN_FORMAT      = 8'h05;
  localparam logic [7:0] FN_PARAMS      = 8'h08;
  localparam logic [7:0] FN_INIT_PARAMS = 8'h09;
  localparam logic [7:0] FN_SEEK        = 8'h0c;
  localparam logic [7:0] FN_ALT_RESET   = 8'h0d;
  localparam logic [7:0] FN_READY       = 8'h10;
  localparam logic [7:0] FN_RECALIBRATE = 8'h11;
  localparam logic [7:0] FN_DIAG        = 8'h14;
  localparam logic [7:0] FN_DRIVE_TYPE  = 8'h15;
  localparam logic [7:0] FN_CHANGE_LINE = 8'h16;

  // Status codes
  localparam logic [7:0] ST_OK     = 8'h00;
  localparam logic [7:0] ST_INVAL  = 8'h01;
  localparam logic [7:0] ST_WPROT  = 8'h03;

  // Media types and drive type codes reported by the geometry function
  localparam logic [2:0] MEDIA_1M2 = 3'd1;
  localparam logic [2:0] MEDIA_1M44 = 3'd2;
  localparam logic [2:0] MEDIA_2M88 = 3'd3;
  localparam logic [7:0] DTYPE_1M2  = 8'h02;
  localparam logic [7:0] DTYPE_1M44 = 8'h04;
  localparam logic [7:0] DTYPE_2M88 = 8'h06;
  localparam logic [7:0] DTYPE_NONE = 8'h00;
  localparam logic [7:0] DRIVE_COUNT = 8'h02;

  // Configuration register indexes
  localparam logic [2:0] REG_EMU_ACTIVE = 3'd0;
  localparam logic [2:0] REG_EMU_DRIVE  = 3'd1;
  localparam logic [2:0] REG_MEDIA      = 3'd2;
  localparam logic [2:0] REG_SPT        = 3'd3;
  localparam logic [2:0] REG_CYLINDERS  = 3'd4;
  localparam logic [2:0] REG_HEADS      = 3'd5;
  localparam logic [2:0] REG_IMAGE_LBA  = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_EMIT
  } state_t;

  // Request, last field in the lowest bits
  typedef struct packed {
    logic [7:0] in_dl;
    logic [7:0] in_dh;
    logic [7:0] in_ch;
    logic [7:0] in_cl;
    logic [7:0] in_al;
    logic [7:0] req_type;
  } req_t;

  // Result, last field in the lowest bits, padded to whole bytes
  typedef struct packed {
    logic [2:0]  pad;
    logic [16:0] transfer_bytes;
    logic [10:0] skip_bytes;
    logic [15:0] read_blocks;
    logic [31:0] read_lba;
    logic [7:0]  out_dl;
    logic [7:0]  out_dh;
    logic [7:0]  out_cl;
    logic [7:0]  out_ch;
    logic [7:0]  out_bl;
    logic [7:0]  out_al;
    logic        carry_flag;
    logic [7:0]  status_code;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/emulated_disk_request_translator.sv -----
// Top level of the emulated disk request translator.
`default_nettype none

// Serves one disk service request per transaction against a disk image held on
// a CD: checks emulation and drive number, answers status, write protection
// and geometry, and for a read turns the CHS address into a CD start block,
// block count, skip bytes and transfer bytes. Every request goes from acceptance
// to the result register through the accept state, two passes through the one
// 20x9 multiplier ((cylinder * heads + head) * sectors per track), and
// a state that finishes the address and loads the result. A result that is
// not taken holds the block in its result state until out_tready rises.
// Configuration writes are taken in every cycle (cfg_ready is always high).
module emulated_disk_request_translator
  import edrt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // req_type, in_al, in_cl, in_ch, in_dh, in_dl
  input  wire logic [47:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status_code, carry_flag, out_al, out_bl, out_ch, out_cl, out_dh, out_dl,
  // read_lba, read_blocks, skip_bytes, transfer_bytes, 3 zero bits
  output logic [135:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  state_t state_r, state_nxt;

  logic        emu_active_r;
  logic [7:0]  emu_drive_r;
  logic [2:0]  media_r;
  logic [5:0]  spt_r;
  logic [10:0] cyls_r;
  logic [8:0]  heads_r;
  logic [31:0] image_lba_r;
  logic [7:0]  last_status_r, last_status_nxt;

  req_t               req_r;
  logic [MUL_P_W-1:0] prod_r;
  rsp_t               out_r;
  logic               out_valid_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               in_acc;
  logic               out_load;
  rsp_t               rsp;

  logic [5:0]        sector;
  logic [9:0]        cyl;
  logic [VLBA_W-1:0] vlba, vlba_end, blk_first, blk_last, blk_rem;
  logic [10:0]       last_cyl;
  logic [8:0]        last_head;
  logic              chs_bad;
  logic              keep;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // Shared multiplier: cylinder * heads, then (that + head) * sectors per track
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = MUL_A_W'(cyl);
      mul_b = heads_r;
    end else begin
      mul_a = prod_r[MUL_A_W-1:0] + MUL_A_W'(req_r.in_dh);
      mul_b = MUL_B_W'(spt_r);
    end
  end
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Address arithmetic, used in the result cycle
  assign sector    = req_r.in_cl[5:0];
  assign cyl       = {req_r.in_cl[7:6], req_r.in_ch};
  assign vlba      = prod_r[VLBA_W-1:0] + VLBA_W'(sector) - VLBA_W'(1);
  assign vlba_end  = vlba + VLBA_W'(req_r.in_al) - VLBA_W'(1);
  assign blk_first = vlba >> SPB_SHIFT;
  assign blk_last  = vlba_end >> SPB_SHIFT;
  assign blk_rem   = vlba & VLBA_W'(SECTORS_PER_BLOCK - 1);
  assign last_cyl  = cyls_r - 11'd1;
  assign last_head = heads_r - 9'd1;
  assign chs_bad   = (sector == 6'd0) || (sector > spt_r) ||
                     ({1'b0, cyl} >= cyls_r) || ({1'b0, req_r.in_dh} >= heads_r);

  always_comb begin
    rsp = '0;
    keep = 1'b1;
    if (!emu_active_r || (emu_drive_r != req_r.in_dl)) begin
      rsp.status_code = ST_INVAL;
      rsp.carry_flag  = 1'b1;
    end else begin
      case (req_r.req_type)
        FN_RESET, FN_INIT_PARAMS, FN_SEEK, FN_ALT_RESET,
        FN_READY, FN_RECALIBRATE, FN_DIAG, FN_CHANGE_LINE: begin
          rsp.status_code = ST_OK;
        end
        FN_WRITE, FN_FORMAT: begin
          rsp.status_code = ST_WPROT;
          rsp.carry_flag  = 1'b1;
        end
        FN_STATUS: begin
          // Report the kept status, then clear it
          rsp.status_code = last_status_r;
          rsp.carry_flag  = (last_status_r != ST_OK);
          keep = 1'b0;
        end
        FN_READ, FN_VERIFY: begin
          if (req_r.in_al == 8'd0) begin
            rsp.status_code = ST_OK;
          end else if (chs_bad) begin
            rsp.status_code = ST_INVAL;
            rsp.carry_flag  = 1'b1;
          end else begin
            rsp.out_al = req_r.in_al;
            if (req_r.req_type == FN_READ) begin
              rsp.read_lba       = image_lba_r + 32'(blk_first);
              rsp.read_blocks    = 16'(blk_last - blk_first + VLBA_W'(1));
              rsp.skip_bytes     = 11'(blk_rem << SECTOR_SHIFT);
              rsp.transfer_bytes = 17'(17'(req_r.in_al) << SECTOR_SHIFT);
            end
          end
        end
        FN_PARAMS: begin
          case (media_r)
            MEDIA_1M2:  rsp.out_bl = DTYPE_1M2;
            MEDIA_1M44: rsp.out_bl = DTYPE_1M44;
            MEDIA_2M88: rsp.out_bl = DTYPE_2M88;
            default:    rsp.out_bl = DTYPE_NONE;
          endcase
          rsp.out_ch = last_cyl[7:0];
          rsp.out_cl = {last_cyl[9:8], spt_r};
          rsp.out_dh = last_head[7:0];
          rsp.out_dl = DRIVE_COUNT;
        end
        FN_DRIVE_TYPE: begin
          rsp.status_code = ST_WPROT;
        end
        default: begin
          rsp.status_code = ST_INVAL;
          rsp.carry_flag  = 1'b1;
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    out_load        = 1'b0;
    last_status_nxt = last_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_MUL1;
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_EMIT;
      S_EMIT: begin
        // Hold until the result register is free
        if (!out_valid_r || out_tready) begin
          out_load        = 1'b1;
          last_status_nxt = (keep && rsp.carry_flag) ? rsp.status_code : ST_OK;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      last_status_r <= ST_OK;
      emu_active_r  <= 1'b0;
      emu_drive_r   <= '0;
      media_r       <= '0;
      spt_r         <= '0;
      cyls_r        <= '0;
      heads_r       <= '0;
      image_lba_r   <= '0;
    end else begin
      state_r       <= state_nxt;
      last_status_r <= last_status_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EMU_ACTIVE: emu_active_r <= cfg_data[0];
          REG_EMU_DRIVE:  emu_drive_r  <= cfg_data[7:0];
          REG_MEDIA:      media_r      <= cfg_data[2:0];
          REG_SPT:        spt_r        <= cfg_data[5:0];
          REG_CYLINDERS:  cyls_r       <= cfg_data[10:0];
          REG_HEADS:      heads_r      <= cfg_data[8:0];
          REG_IMAGE_LBA:  image_lba_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) req_r <= in_tdata;
    if (state_r == S_MUL1 || state_r == S_MUL2) prod_r <= mul_p;
    if (out_load) out_r <= rsp;
  end

  // A request keeps the input closed for the rest of its work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input reopened while a request is in work");

  // A successful request leaves a clear kept status
  a_status_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !rsp.carry_flag |=> last_status_r == ST_OK)
    else $error("kept status not cleared after success");

  // An issued read covers at least one block
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && rsp.transfer_bytes != 17'd0 |-> rsp.read_blocks != 16'd0)
    else $error("read issued with no blocks");

  // Skip stays inside one CD block
  a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_r.skip_bytes <= 11'(SKIP_MAX))
    else $error("skip bytes beyond one block");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the emulated disk request translator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import edrt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 170;

  typedef struct packed {
    logic        active;
    logic [7:0]  drive;
    logic [2:0]  media;
    logic [5:0]  spt;
    logic [10:0] cyls;
    logic [8:0]  heads;
    logic [31:0] lba;
  } geom_t;

  typedef struct {
    bit   setup_first;
    req_t req;
    bit   preset;
    rsp_t rsp;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // Shadow of the block's registers and kept status
  logic        emu_active = 1'b0;
  logic [7:0]  emu_drive = '0;
  logic [2:0]  media_kind = '0;
  logic [5:0]  spt = '0;
  logic [10:0] cyls = '0;
  logic [8:0]  heads = '0;
  logic [31:0] image_base = '0;
  logic [7:0]  disk_status = '0;

  rsp_t pending[$];
  row_t rows[$];
  int   mismatches = 0;
  int   send_idle_pct = 13;
  int   recv_idle_pct = 70;
  bit   hold_go = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left = 0;
  int   quiet = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  emulated_disk_request_translator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Work out the reply to one request and advance the kept status
  function automatic rsp_t serve_request(req_t r);
    rsp_t        o;
    logic [5:0]  sector;
    logic [9:0]  cyl;
    logic [31:0] vlba;
    logic [31:0] first_blk;
    logic [31:0] last_blk;
    logic [15:0] last_cyl;
    logic [15:0] last_head;
    logic [7:0]  prior;
    bit          clears;
    o = '0;
    prior = disk_status;
    clears = 1'b0;
    if (!emu_active || emu_drive != r.in_dl) begin
      o.status_code = ST_INVAL;
      o.carry_flag = 1'b1;
    end else begin
      case (r.req_type)
        FN_RESET, FN_INIT_PARAMS, FN_SEEK, FN_ALT_RESET,
        FN_READY, FN_RECALIBRATE, FN_DIAG, FN_CHANGE_LINE: begin
          o.status_code = ST_OK;
        end
        FN_WRITE, FN_FORMAT: begin
          o.status_code = ST_WPROT;
          o.carry_flag = 1'b1;
        end
        FN_STATUS: begin
          o.status_code = prior;
          o.carry_flag = (prior != 8'h00);
          clears = 1'b1;
        end
        FN_READ, FN_VERIFY: begin
          sector = r.in_cl[5:0];
          cyl = {r.in_cl[7:6], r.in_ch};
          if (r.in_al == 8'h00) begin
            o.status_code = ST_OK;
          end else if (sector == 6'd0 || sector > spt || cyl >= cyls || r.in_dh >= heads) begin
            o.status_code = ST_INVAL;
            o.carry_flag = 1'b1;
          end else begin
            o.out_al = r.in_al;
            if (r.req_type == FN_READ) begin
              vlba = (32'(cyl) * 32'(heads) + 32'(r.in_dh)) * 32'(spt) + 32'(sector) - 32'd1;
              first_blk = vlba / SECTORS_PER_BLOCK;
              last_blk = (vlba + 32'(r.in_al) - 32'd1) / SECTORS_PER_BLOCK;
              o.read_lba = image_base + first_blk;
              o.read_blocks = 16'(last_blk - first_blk + 32'd1);
              o.skip_bytes = 11'((vlba % SECTORS_PER_BLOCK) * SECTOR_BYTES);
              o.transfer_bytes = 17'(32'(r.in_al) * SECTOR_BYTES);
            end
          end
        end
        FN_PARAMS: begin
          last_cyl = 16'(cyls) - 16'd1;
          last_head = 16'(heads) - 16'd1;
          case (media_kind)
            MEDIA_1M2:  o.out_bl = DTYPE_1M2;
            MEDIA_1M44: o.out_bl = DTYPE_1M44;
            MEDIA_2M88: o.out_bl = DTYPE_2M88;
            default:    o.out_bl = DTYPE_NONE;
          endcase
          o.out_ch = last_cyl[7:0];
          o.out_cl = {last_cyl[9:8], spt};
          o.out_dh = last_head[7:0];
          o.out_dl = DRIVE_COUNT;
        end
        FN_DRIVE_TYPE: begin
          o.status_code = ST_WPROT;
        end
        default: begin
          o.status_code = ST_INVAL;
          o.carry_flag = 1'b1;
        end
      endcase
    end
    if (clears) disk_status = 8'h00;
    else disk_status = o.carry_flag ? o.status_code : 8'h00;
    return o;
  endfunction

  function automatic rsp_t status_reply(logic [7:0] st, logic cf);
    rsp_t o;
    o = '0;
    o.status_code = st;
    o.carry_flag = cf;
    return o;
  endfunction

  function automatic logic [7:0] pick_known_fn();
    case ($urandom_range(14))
      0:  return FN_RESET;
      1:  return FN_STATUS;
      2:  return FN_READ;
      3:  return FN_WRITE;
      4:  return FN_VERIFY;
      5:  return FN_FORMAT;
      6:  return FN_PARAMS;
      7:  return FN_INIT_PARAMS;
      8:  return FN_SEEK;
      9:  return FN_ALT_RESET;
      10: return FN_READY;
      11: return FN_RECALIBRATE;
      12: return FN_DIAG;
      13: return FN_DRIVE_TYPE;
      default: return FN_CHANGE_LINE;
    endcase
  endfunction

  // Mostly reads and verifies aimed inside the geometry, the rest noise
  function automatic req_t random_request();
    req_t       r;
    logic [9:0] cyl;
    logic [5:0] sector;
    int         pick;
    r = req_t'(48'({$urandom, $urandom}));
    if ($urandom_range(99) < 90) r.in_dl = emu_drive;
    pick = $urandom_range(99);
    if (pick < 55) begin
      r.req_type = $urandom_range(1) ? FN_READ : FN_VERIFY;
      if ($urandom_range(99) < 80 && spt != 0 && cyls != 0 && heads != 0) begin
        sector = 6'($urandom_range(1, spt));
        cyl = 10'($urandom_range(0, cyls - 1));
        r.in_cl = {cyl[9:8], sector};
        r.in_ch = cyl[7:0];
        r.in_dh = 8'($urandom_range(0, heads - 1));
      end
    end else if (pick < 90) begin
      r.req_type = pick_known_fn();
    end
    case ($urandom_range(19))
      0: r.in_al = 8'h00;
      1: r.in_al = 8'hff;
      default: ;
    endcase
    return r;
  endfunction

  function automatic geom_t random_geometry(int ph);
    geom_t g;
    case (ph)
      0: g = '{1'b1, 8'hff, 3'd4, 6'd63, 11'd1024, 9'd256, 32'hffff_ffff};
      1: g = '{1'b1, 8'h00, 3'd0, 6'd0, 11'd0, 9'd0, 32'h0000_0000};
      default: begin
        g.active = (ph != 2);
        g.drive = 8'($urandom);
        g.media = 3'(ph % 5);
        g.spt = 6'($urandom_range(1, 63));
        g.cyls = 11'($urandom_range(1, 1024));
        g.heads = 9'($urandom_range(1, 256));
        g.lba = $urandom;
      end
    endcase
    return g;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic check_reply(rsp_t got, rsp_t want);
    if (got.status_code !== want.status_code) report("status_code", got.status_code, want.status_code);
    if (got.carry_flag !== want.carry_flag) report("carry_flag", got.carry_flag, want.carry_flag);
    if (got.out_al !== want.out_al) report("out_al", got.out_al, want.out_al);
    if (got.out_bl !== want.out_bl) report("out_bl", got.out_bl, want.out_bl);
    if (got.out_ch !== want.out_ch) report("out_ch", got.out_ch, want.out_ch);
    if (got.out_cl !== want.out_cl) report("out_cl", got.out_cl, want.out_cl);
    if (got.out_dh !== want.out_dh) report("out_dh", got.out_dh, want.out_dh);
    if (got.out_dl !== want.out_dl) report("out_dl", got.out_dl, want.out_dl);
    if (got.read_lba !== want.read_lba) report("read_lba", got.read_lba, want.read_lba);
    if (got.read_blocks !== want.read_blocks) report("read_blocks", got.read_blocks, want.read_blocks);
    if (got.skip_bytes !== want.skip_bytes) report("skip_bytes", got.skip_bytes, want.skip_bytes);
    if (got.transfer_bytes !== want.transfer_bytes)
      report("transfer_bytes", got.transfer_bytes, want.transfer_bytes);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last register
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_EMU_ACTIVE: emu_active = val[0];
      REG_EMU_DRIVE:  emu_drive = val[7:0];
      REG_MEDIA:      media_kind = val[2:0];
      REG_SPT:        spt = val[5:0];
      REG_CYLINDERS:  cyls = val[10:0];
      REG_HEADS:      heads = val[8:0];
      REG_IMAGE_LBA:  image_base = val;
      default: ;
    endcase
  endtask

  task automatic apply_geometry(geom_t g);
    write_reg(REG_EMU_ACTIVE, 32'(g.active));
    write_reg(REG_EMU_DRIVE, 32'(g.drive));
    write_reg(REG_MEDIA, 32'(g.media));
    write_reg(REG_SPT, 32'(g.spt));
    write_reg(REG_CYLINDERS, 32'(g.cyls));
    write_reg(REG_HEADS, 32'(g.heads));
    write_reg(REG_IMAGE_LBA, g.lba);
    cfg_valid <= 1'b0;
  endtask

  // Leaves in_tvalid high so back-to-back requests need no gap
  task automatic send_request(req_t r, bit preset, rsp_t fixed_rsp);
    rsp_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= r;
    do @(posedge clk); while (!in_tready);
    predicted = serve_request(r);
    pending.push_back(preset ? fixed_rsp : predicted);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic add_row(bit setup, logic [7:0] fn, logic [7:0] al, logic [7:0] cl,
                         logic [7:0] ch, logic [7:0] dh, logic [7:0] dl,
                         bit preset, logic [7:0] st, logic cf);
    row_t row;
    row.setup_first = setup;
    row.req = '{in_dl: dl, in_dh: dh, in_ch: ch, in_cl: cl, in_al: al, req_type: fn};
    row.preset = preset;
    row.rsp = status_reply(st, cf);
    rows.push_back(row);
  endtask

  // Receiver: random backpressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) report("reply with no request pending", 0, 0);
      else check_reply(rsp_t'(out_tdata), pending.pop_front());
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    geom_t base_geom;
    base_geom = '{1'b1, 8'h80, 3'd2, 6'd18, 11'd80, 9'd2, 32'hffff_fff0};

    // Emulation off after reset: everything is refused and the status kept
    add_row(0, FN_READ, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 1, ST_INVAL, 1'b1);
    add_row(0, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, ST_INVAL, 1'b1);
    // 1.44M floppy image near the top of the CD address space
    add_row(1, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_INVAL, 1'b1);
    add_row(0, FN_READ, 8'h01, 8'h01, 8'h00, 8'h00, 8'h7f, 1, ST_INVAL, 1'b1);
    add_row(0, FN_WRITE, 8'h01, 8'h01, 8'h00, 8'h00, 8'h80, 1, ST_WPROT, 1'b1);
    add_row(0, FN_FORMAT, 8'h01, 8'h01, 8'h00, 8'h00, 8'h80, 1, ST_WPROT, 1'b1);
    add_row(0, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_WPROT, 1'b1);
    add_row(0, FN_DRIVE_TYPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_WPROT, 1'b0);
    add_row(0, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, FN_RESET, 8'hff, 8'hff, 8'hff, 8'hff, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, FN_INIT_PARAMS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, FN_SEEK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, FN_ALT_RESET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, FN_READY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, FN_RECALIBRATE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, FN_DIAG, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, FN_CHANGE_LINE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_INVAL, 1'b1);
    add_row(0, FN_READ, 8'h00, 8'h00, 8'hff, 8'hff, 8'h80, 1, ST_OK, 1'b0);
    add_row(0, FN_READ, 8'h01, 8'h00, 8'h00, 8'h00, 8'h80, 1, ST_INVAL, 1'b1);
    add_row(0, FN_VERIFY, 8'h01, 8'h13, 8'h00, 8'h00, 8'h80, 1, ST_INVAL, 1'b1);
    add_row(0, FN_READ, 8'h01, 8'h01, 8'h50, 8'h00, 8'h80, 1, ST_INVAL, 1'b1);
    add_row(0, FN_READ, 8'h01, 8'h01, 8'h00, 8'h02, 8'h80, 1, ST_INVAL, 1'b1);
    add_row(0, FN_READ, 8'hff, 8'h12, 8'h4f, 8'h01, 8'h80, 0, ST_OK, 1'b0);
    add_row(0, FN_VERIFY, 8'h01, 8'h01, 8'h00, 8'h00, 8'h80, 0, ST_OK, 1'b0);
    add_row(0, FN_PARAMS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 0, ST_OK, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].setup_first) begin
        drain();
        apply_geometry(base_geom);
      end
      send_request(rows[i].req, rows[i].preset, rows[i].rsp);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph * 3 / PHASES)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct <= 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct <= 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      apply_geometry(random_geometry(ph));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the receiver off while requests keep coming
        if (ph == 3 && n == 40) hold_go <= 1'b1;
        send_request(random_request(), 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (pending.size() != 0) report("replies never delivered", pending.size(), 0);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/edrt_pkg.sv
hw/rtl/emulated_disk_request_translator.sv
bench/tb_top.sv
